/* hdl/gcpwm_pkg.sv */
// Package for the gamma-corrected LED PWM: field widths, item kind codes
// and the perceptual duty table. No dependencies.
package gcpwm_pkg;

	localparam int PIXEL_COUNT_DEF = 5;
	localparam int PIXEL_MAX       = 16;
	localparam int DUTY_W          = 8;
	localparam int LEVEL_W         = 8;
	localparam int LINE_COUNT      = 15;
	localparam int IN_TDATA_W      = 32;
	localparam int OUT_TDATA_W     = 16;
	localparam int COLOR_COUNT     = 3;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd31;

	typedef enum logic {
		MODE_SET  = 1'b0,
		MODE_TICK = 1'b1
	} mode_t;

	typedef logic [DUTY_W-1:0] duty_t;

	localparam duty_t GAMMA_TABLE [32] = '{
		8'd0,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd3,   8'd3,
		8'd4,   8'd5,   8'd6,   8'd7,   8'd9,   8'd10,  8'd12,  8'd15,
		8'd17,  8'd21,  8'd25,  8'd30,  8'd36,  8'd43,  8'd51,  8'd61,
		8'd73,  8'd87,  8'd104, 8'd125, 8'd149, 8'd178, 8'd213, 8'd255
	};

endpackage

/* hdl/gamma_corrected_led_pwm.sv */
// Top level of the gamma-corrected LED PWM: input register, duty store,
// step counter and result register. Depends on gcpwm_pkg.
//
// Usage:
//   Input stream (s_axis_*): tuser selects the kind of item. A set item
//   (tuser = 0) loads three 8-bit levels for one pixel; each level goes
//   through the gamma table and is stored as an 8-bit duty. A pixel index
//   at or above PIXEL_COUNT is dropped; a level above 31 leaves that color
//   as it was. A tick item (tuser = 1) compares the step counter with all
//   stored duties (on while step < duty), sends one transfer with the 15
//   line states and then advances the counter, wrapping at 256.
//   Output stream (m_axis_*): one transfer per tick; set items send none.
//   Timing: an item is held in the input register, and a tick's result is
//   loaded into the output register as the tick leaves it, so its lines
//   are offered from there. One item per cycle is taken while no tick is
//   stalled; stage one refills in the cycle its item moves on.
//   Stall: while the output register holds an untaken result, a tick in
//   the input register waits and the input stops; set items still pass.
//   Reset: arst_n clears the counter, all duties (every line off) and
//   both valid flags.
module gamma_corrected_led_pwm #(
	parameter int PIXEL_COUNT = gcpwm_pkg::PIXEL_COUNT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// tdata from bit 0 up: pixel_index[7:0], red_level[15:8],
	// green_level[23:16], blue_level[31:24]
	input  logic [gcpwm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// tuser: mode (0 = set pixel levels, 1 = PWM step tick)
	input  logic                                  s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// tdata from bit 0 up: led_lines[14:0], zero pad bit 15
	output logic [gcpwm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import gcpwm_pkg::*;

	localparam int CHANNEL_COUNT = COLOR_COUNT * PIXEL_COUNT;

	// Input register
	logic                  valid_s1;
	mode_t                 mode_s1;
	logic [IN_TDATA_W-1:0] data_s1;

	// Result register
	logic                   out_valid_q;
	logic [LINE_COUNT-1:0]  lines_q;

	logic  [DUTY_W-1:0]     step_q;
	duty_t                  duty_q [CHANNEL_COUNT];

	logic                   out_free;
	logic                   adv_s1;
	logic                   tick_adv;
	logic                   set_adv;
	logic [LINE_COUNT-1:0]  lines_next;
	logic [7:0]             pixel_s1;
	logic [LEVEL_W-1:0]     level_s1 [COLOR_COUNT];

	assign out_free = !out_valid_q || m_axis_tready;
	// A set item never waits on the output; a tick needs the slot free.
	assign adv_s1   = valid_s1 && ((mode_s1 == MODE_SET) || out_free);
	assign tick_adv = adv_s1 && (mode_s1 == MODE_TICK);
	assign set_adv  = adv_s1 && (mode_s1 == MODE_SET);

	assign s_axis_tready = !valid_s1 || adv_s1;

	assign pixel_s1    = data_s1[7:0];
	assign level_s1[0] = data_s1[15:8];
	assign level_s1[1] = data_s1[23:16];
	assign level_s1[2] = data_s1[31:24];

	// Input register: take a new transfer whenever the stage empties.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1 <= mode_t'(s_axis_tuser);
			data_s1 <= s_axis_tdata;
		end
	end

	// Duty store: one register per channel, written only by its own pixel.
	for (genvar ch = 0; ch < CHANNEL_COUNT; ch++) begin : g_duty
		localparam int PX  = ch / COLOR_COUNT;
		localparam int COL = ch % COLOR_COUNT;

		logic load;
		assign load = set_adv && (pixel_s1 == 8'(PX)) && (level_s1[COL] <= LEVEL_MAX);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				duty_q[ch] <= '0;
			end else if (load) begin
				duty_q[ch] <= GAMMA_TABLE[level_s1[COL][4:0]];
			end
		end
	end

	// Line compare: channels without a pixel behind them stay off.
	for (genvar ln = 0; ln < LINE_COUNT; ln++) begin : g_line
		if (ln < CHANNEL_COUNT) begin : g_on
			assign lines_next[ln] = step_q < duty_q[ln];
		end else begin : g_off
			assign lines_next[ln] = 1'b0;
		end
	end

	// Step counter: advance after every tick, wrap at 256.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (tick_adv) begin
			step_q <= step_q + 1'b1;
		end
	end

	// Result register: hold until taken, load when a tick leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= tick_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_adv) begin
			lines_q <= lines_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - LINE_COUNT){1'b0}}, lines_q};

`ifndef NO_ASSERTIONS
	a_step_adv: assert property (@(posedge clk) disable iff (!arst_n)
		tick_adv |=> step_q == $past(step_q) + 8'd1)
		else $error("step counter did not advance after a tick");

	a_step_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_adv |=> $stable(step_q))
		else $error("step counter moved without a tick");

	a_tick_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && mode_s1 == MODE_TICK && out_valid_q && !m_axis_tready) |-> !adv_s1)
		else $error("tick left stage one while the result was stalled");

	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(tick_adv))
		else $error("result appeared without a tick");
`endif

endmodule
